[src/rcwc_pkg.sv]
// Shared types, constants and helpers for the Reno congestion window controller.
package rcwc_pkg;

	localparam int NUM_PEERS     = 16;
	localparam int DUP_THRESHOLD = 3;

	localparam int PEER_W  = 4;
	localparam int SEQ_W   = 8;
	localparam int DUP_W   = 8;
	localparam int Q_W     = 16;
	localparam int LIMIT_W = 8;
	localparam int PEER_AW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;

	localparam logic [Q_W-1:0]   Q_ONE    = Q_W'(256);
	localparam logic [Q_W-1:0]   Q_TWO    = Q_W'(512);
	localparam logic [Q_W-1:0]   Q_DUPADD = Q_W'(DUP_THRESHOLD * 256);
	localparam logic [Q_W-1:0]   Q_SSINIT = Q_W'(64 * 256);
	localparam logic [DUP_W-1:0] DUP_MAX  = {DUP_W{1'b1}};
	localparam logic [DUP_W-1:0] DUP_THR  = DUP_W'(DUP_THRESHOLD);

	// reciprocal unit: 2^Q_W / cwnd, one quotient bit per cycle
	localparam int             DIV_W        = Q_W + 1;
	localparam int             DIV_CNT_W    = $clog2(DIV_W + 1);
	localparam logic [DIV_W-1:0] DIV_DIVIDEND = DIV_W'(1) << Q_W;

	typedef enum logic [1:0] {
		FUNC_ACK     = 2'd0,
		FUNC_TIMEOUT = 2'd1,
		FUNC_SEND    = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_SS   = 2'd0,
		MODE_AIMD = 2'd1,
		MODE_FR   = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	typedef struct packed {
		logic [Q_W-1:0]   cwnd;
		logic [Q_W-1:0]   ssthresh;
		mode_t            mode;
		logic [DUP_W-1:0] dup;
		logic [SEQ_W-1:0] last_acked;
		logic [SEQ_W-1:0] last_sent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY_RESET = '{
		cwnd:       Q_ONE,
		ssthresh:   Q_SSINIT,
		mode:       MODE_SS,
		dup:        '0,
		last_acked: '0,
		last_sent:  '0
	};

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// saturating Q8.8 add
	function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
		input logic [DIV_W-1:0] b);
		logic [DIV_W:0] sum;
		sum = {2'b00, a} + {1'b0, b};
		return (sum > (DIV_W+1)'({Q_W{1'b1}})) ? {Q_W{1'b1}} : sum[Q_W-1:0];
	endfunction

endpackage

[src/rcwc_if.sv]
// Request and response channel interfaces for the congestion window controller.
interface rcwc_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [rcwc_pkg::PEER_W-1:0]   peer;
	logic [rcwc_pkg::SEQ_W-1:0]    ack_seq;
	logic                          crc_ok;

	modport source (output valid, func, peer, ack_seq, crc_ok, input ready);
	modport sink   (input valid, func, peer, ack_seq, crc_ok, output ready);
endinterface

interface rcwc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rcwc_pkg::SEQ_W-1:0]    seq_assigned;
	logic                          ack_new;
	logic                          fast_retransmit;
	logic [1:0]                    mode_out;
	logic [rcwc_pkg::Q_W-1:0]      cwnd_out;
	logic [rcwc_pkg::Q_W-1:0]      ssthresh_out;
	logic [rcwc_pkg::LIMIT_W-1:0]  eff_window;

	modport source (output valid, seq_assigned, ack_new, fast_retransmit, mode_out,
		cwnd_out, ssthresh_out, eff_window, input ready);
	modport sink   (input valid, seq_assigned, ack_new, fast_retransmit, mode_out,
		cwnd_out, ssthresh_out, eff_window, output ready);
endinterface

[src/rcwc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rcwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/rcwc_div.sv]
// Restoring divider: 2^16 / divisor, one quotient bit per cycle.
module rcwc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rcwc_pkg::Q_W-1:0]       divisor,
	output rcwc_pkg::div_stat_t            stat,
	output logic [rcwc_pkg::DIV_W-1:0]     quotient
);

	logic                               busy_q;
	logic                               done_q;
	logic [rcwc_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [rcwc_pkg::DIV_W-1:0]         rem_q;
	logic [rcwc_pkg::DIV_W-1:0]         quo_q;
	logic [rcwc_pkg::DIV_W-1:0]         dvd_q;
	logic [rcwc_pkg::Q_W-1:0]           dvs_q;
	logic [rcwc_pkg::DIV_W-1:0]         rem_sh;
	logic                               fits;

	assign rem_sh = {rem_q[rcwc_pkg::DIV_W-2:0], dvd_q[rcwc_pkg::DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rcwc_pkg::DIV_CNT_W'(rcwc_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rcwc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= rcwc_pkg::DIV_DIVIDEND;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[rcwc_pkg::DIV_W-2:0], fits};
			dvd_q <= {dvd_q[rcwc_pkg::DIV_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[src/reno_congestion_window_controller_core.sv]
// Top level: per-peer Reno congestion window controller around a state RAM.
//
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+---------------------------------------------
// req      | in  | valid / ready    | func, peer, ack_seq, crc_ok
// rsp      | out | valid / ready    | seq_assigned, ack_new, fast_retransmit,
//          |     |                  | mode_out, cwnd_out, ssthresh_out, eff_window
// cfg      | in  | cfg_we           | cfg_wdata -> window_limit
//
// One request at a time. Accept -> RAM read -> update -> write back, with a divide
// step between update and write back when a valid ack needs the AIMD step (the
// bit-serial reciprocal 65536/cwnd holds the divide state for 17 quotient bits plus done).
// Reset: all control state cleared, per-peer valid bits cleared so every peer
// reads as cwnd 1.0, ssthresh 64.0, slow start; window_limit goes to 8. No
// clearing pass is needed.
// A new request is taken while a finished response still waits in the output
// register; write back stalls only if that register is still occupied.
module reno_congestion_window_controller_core (
	input  logic                         clk,
	input  logic                         arst_n,
	rcwc_req_if.sink                     req,
	rcwc_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [rcwc_pkg::LIMIT_W-1:0] cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_WB   = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [rcwc_pkg::LIMIT_W-1:0]    window_limit_q;
	logic [rcwc_pkg::NUM_PEERS-1:0]  valid_q;

	// latched request
	rcwc_pkg::func_t                 func_q;
	logic [rcwc_pkg::PEER_AW-1:0]    addr_q;
	logic                            in_range_q;
	logic [rcwc_pkg::SEQ_W-1:0]      ack_seq_q;
	logic                            crc_ok_q;

	// working copy of the entry plus per-request flags
	rcwc_pkg::entry_t                work_q;
	logic                            ack_new_q;
	logic                            fr_q;
	logic [rcwc_pkg::SEQ_W-1:0]      seq_q;

	// output register
	logic                            rsp_vld_q;
	logic [rcwc_pkg::SEQ_W-1:0]      rsp_seq_q;
	logic                            rsp_ack_q;
	logic                            rsp_fr_q;
	logic [1:0]                      rsp_mode_q;
	logic [rcwc_pkg::Q_W-1:0]        rsp_cwnd_q;
	logic [rcwc_pkg::Q_W-1:0]        rsp_ssth_q;
	logic [rcwc_pkg::LIMIT_W-1:0]    rsp_eff_q;

	logic                            accept;
	logic                            in_range;
	logic [rcwc_pkg::PEER_AW-1:0]    req_addr;
	logic [rcwc_pkg::ENTRY_W-1:0]    ram_rdata;
	logic                            ram_we;
	logic                            out_free;
	logic                            wb_go;

	rcwc_pkg::entry_t                cur;
	rcwc_pkg::entry_t                nxt;
	logic                            nxt_ack_new;
	logic                            nxt_fr;
	logic [rcwc_pkg::SEQ_W-1:0]      nxt_seq;
	logic                            need_div;
	logic [rcwc_pkg::SEQ_W-1:0]      span;
	logic [rcwc_pkg::SEQ_W-1:0]      ahead;
	logic                            ack_ok;
	logic [rcwc_pkg::DUP_W-1:0]      dup1;
	logic [rcwc_pkg::Q_W-1:0]        c1;
	logic [rcwc_pkg::Q_W-1:0]        half;
	logic [rcwc_pkg::Q_W-1:0]        s1;
	logic [rcwc_pkg::LIMIT_W-1:0]    whole;
	logic [rcwc_pkg::LIMIT_W-1:0]    eff;

	logic                            div_start;
	rcwc_pkg::div_stat_t             div_stat;
	logic [rcwc_pkg::DIV_W-1:0]      div_quo;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign in_range = (32'(req.peer) < rcwc_pkg::NUM_PEERS);
	assign req_addr = rcwc_pkg::PEER_AW'(req.peer);
	assign out_free = !rsp_vld_q || rsp.ready;
	assign wb_go    = (state_q == ST_WB) && out_free;
	assign ram_we   = wb_go && in_range_q;

	// state RAM: one 58-bit entry per peer
	rcwc_ram #(
		.WIDTH(rcwc_pkg::ENTRY_W),
		.DEPTH(rcwc_pkg::NUM_PEERS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (work_q),
		.re    (accept),
		.raddr (req_addr),
		.rdata (ram_rdata)
	);

	// entries never written read as their reset value
	assign cur = valid_q[addr_q] ? rcwc_pkg::entry_t'(ram_rdata) : rcwc_pkg::ENTRY_RESET;

	// event update
	always_comb begin
		span        = cur.last_sent - cur.last_acked;
		ahead       = ack_seq_q - cur.last_acked;
		ack_ok      = crc_ok_q && (ahead != '0) && (ahead <= span);
		nxt         = cur;
		nxt_ack_new = 1'b0;
		nxt_fr      = 1'b0;
		nxt_seq     = '0;
		need_div    = 1'b0;
		dup1        = (cur.dup < rcwc_pkg::DUP_MAX) ? cur.dup + 1'b1 : cur.dup;
		c1          = (cur.mode == rcwc_pkg::MODE_FR)
			? rcwc_pkg::sat_add(cur.cwnd, rcwc_pkg::DIV_W'(rcwc_pkg::Q_ONE)) : cur.cwnd;
		half        = c1 >> 1;
		s1          = (half < rcwc_pkg::Q_TWO) ? rcwc_pkg::Q_TWO : half;
		case (func_q)
			rcwc_pkg::FUNC_ACK: begin
				if (ack_ok) begin
					nxt_ack_new    = 1'b1;
					nxt.dup        = '0;
					nxt.last_acked = ack_seq_q;
					case (cur.mode)
						rcwc_pkg::MODE_SS: begin
							if (cur.cwnd <= cur.ssthresh) begin
								nxt.cwnd = rcwc_pkg::sat_add(cur.cwnd,
									rcwc_pkg::DIV_W'(rcwc_pkg::Q_ONE));
							end else begin
								// leaves slow start and takes the AIMD step now
								nxt.mode = rcwc_pkg::MODE_AIMD;
								need_div = 1'b1;
							end
						end
						rcwc_pkg::MODE_FR: begin
							nxt.cwnd = cur.ssthresh;
							nxt.mode = rcwc_pkg::MODE_AIMD;
						end
						rcwc_pkg::MODE_AIMD: begin
							need_div = cur.cwnd > cur.ssthresh;
						end
						default: begin
						end
					endcase
				end else begin
					nxt.dup  = dup1;
					nxt.cwnd = c1;
					if (dup1 == rcwc_pkg::DUP_THR) begin
						nxt.mode     = rcwc_pkg::MODE_FR;
						nxt.ssthresh = s1;
						nxt.cwnd     = rcwc_pkg::sat_add(s1,
							rcwc_pkg::DIV_W'(rcwc_pkg::Q_DUPADD));
						nxt_fr       = 1'b1;
					end
				end
			end
			rcwc_pkg::FUNC_TIMEOUT: begin
				nxt.ssthresh = cur.cwnd >> 1;
				nxt.cwnd     = rcwc_pkg::Q_ONE;
				nxt.mode     = rcwc_pkg::MODE_SS;
			end
			rcwc_pkg::FUNC_SEND: begin
				nxt.last_sent = cur.last_sent + 1'b1;
				nxt_seq       = cur.last_sent + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == ST_EXEC) && in_range_q && need_div;

	rcwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (cur.cwnd),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// effective window: whole frames of cwnd, capped by window_limit
	assign whole = work_q.cwnd[rcwc_pkg::Q_W-1 -: rcwc_pkg::LIMIT_W];
	assign eff   = (whole < window_limit_q) ? whole : window_limit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			window_limit_q <= rcwc_pkg::LIMIT_W'(8);
			valid_q        <= '0;
			rsp_vld_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_limit_q <= cfg_wdata;
			end
			if (ram_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (wb_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= div_start ? ST_DIV : ST_WB;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= rcwc_pkg::func_t'(req.func);
			addr_q     <= req_addr;
			in_range_q <= in_range;
			ack_seq_q  <= req.ack_seq;
			crc_ok_q   <= req.crc_ok;
		end
		if (state_q == ST_EXEC) begin
			work_q    <= nxt;
			ack_new_q <= nxt_ack_new;
			fr_q      <= nxt_fr;
			seq_q     <= nxt_seq;
		end
		if ((state_q == ST_DIV) && div_stat.done) begin
			work_q.cwnd <= rcwc_pkg::sat_add(work_q.cwnd, div_quo);
		end
		if (wb_go) begin
			if (in_range_q) begin
				rsp_seq_q  <= seq_q;
				rsp_ack_q  <= ack_new_q;
				rsp_fr_q   <= fr_q;
				rsp_mode_q <= work_q.mode;
				rsp_cwnd_q <= work_q.cwnd;
				rsp_ssth_q <= work_q.ssthresh;
				rsp_eff_q  <= eff;
			end else begin
				// unknown peer: all-zero response
				rsp_seq_q  <= '0;
				rsp_ack_q  <= 1'b0;
				rsp_fr_q   <= 1'b0;
				rsp_mode_q <= '0;
				rsp_cwnd_q <= '0;
				rsp_ssth_q <= '0;
				rsp_eff_q  <= '0;
			end
		end
	end

	assign rsp.valid           = rsp_vld_q;
	assign rsp.seq_assigned    = rsp_seq_q;
	assign rsp.ack_new         = rsp_ack_q;
	assign rsp.fast_retransmit = rsp_fr_q;
	assign rsp.mode_out        = rsp_mode_q;
	assign rsp.cwnd_out        = rsp_cwnd_q;
	assign rsp.ssthresh_out    = rsp_ssth_q;
	assign rsp.eff_window      = rsp_eff_q;

	// an accepted request always starts with the RAM read
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RD)
		else $error("request accepted without RAM read");

	// write back always hands a response to the output register
	a_wb_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> rsp.valid)
		else $error("state written back without response");

	// cwnd never falls below one frame
	a_cwnd_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> work_q.cwnd >= rcwc_pkg::Q_ONE)
		else $error("cwnd written below 1.0");

	// reciprocal finishes only while waiting on it, and is never zero
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV) && (div_quo != '0))
		else $error("unexpected reciprocal result");

	// reciprocal unit is only started when idle
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("reciprocal started while busy");

endmodule

[verif/reno_congestion_window_controller_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Reno congestion window controller core.
module reno_congestion_window_controller_core_test;

	// Run limits. ~1800 requests, each at the slowest legal request latency with the
	// longest idle gap on each side, stay well under this.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASE_REQS  = 250;
	localparam int unsigned SETTLE_CYC  = 25;   // > AIMD request latency
	localparam logic [15:0] ONE_Q = 16'd256;    // 1.0 in Q8.8
	localparam logic [15:0] TWO_Q = 16'd512;    // 2.0 in Q8.8

	// One response as the core reports it.
	typedef struct packed {
		logic [rcwc_pkg::SEQ_W-1:0]   seq;
		logic                         ack_new;
		logic                         fast_rtx;
		rcwc_pkg::mode_t              mode;
		logic [rcwc_pkg::Q_W-1:0]     cwnd;
		logic [rcwc_pkg::Q_W-1:0]     ssth;
		logic [rcwc_pkg::LIMIT_W-1:0] eff;
	} outcome_t;

	// Directed request; 'typed' rows carry a hand-derived response, the rest
	// are checked against the window predictor only.
	typedef struct packed {
		rcwc_pkg::func_t             func;
		logic [rcwc_pkg::PEER_W-1:0] peer;
		logic [rcwc_pkg::SEQ_W-1:0]  ack_seq;
		logic                        crc_ok;
		logic                        typed;
		outcome_t                    want;
	} script_row_t;

	localparam int N_SCRIPT = 24;
	localparam script_row_t SCRIPT [0:N_SCRIPT-1] = '{
		// stale ack straight out of reset: nothing in flight, counts as a duplicate
		'{rcwc_pkg::FUNC_ACK, 4'd0, 8'd0, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd16384, 8'd1}},
		// first send on the top peer, ack_seq ignored
		'{rcwc_pkg::FUNC_SEND, 4'd15, 8'd255, 1'b0, 1'b1,
			'{8'd1, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd16384, 8'd1}},
		// unused event code only reports state
		'{rcwc_pkg::FUNC_NONE, 4'd15, 8'd255, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd16384, 8'd1}},
		// corrupted ack on an in-window seq is a duplicate
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd1, 1'b0, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd16384, 8'd1}},
		// good ack: slow start +1.0, dup count cleared
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd1, 1'b1, 1'b1,
			'{8'd0, 1'b1, 1'b0, rcwc_pkg::MODE_SS, 16'd512, 16'd16384, 8'd2}},
		// repeat of last acked seq
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd1, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd512, 16'd16384, 8'd2}},
		// beyond last sent
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd200, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd512, 16'd16384, 8'd2}},
		// third duplicate: fast retransmit, ssthresh floored at 2.0, cwnd = 2.0 + 3
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd1, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b1, rcwc_pkg::MODE_FR, 16'd1280, 16'd512, 8'd5}},
		// duplicate while in fast recovery inflates cwnd by 1.0
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd1, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_FR, 16'd1536, 16'd512, 8'd6}},
		'{rcwc_pkg::FUNC_SEND, 4'd15, 8'd0, 1'b0, 1'b1,
			'{8'd2, 1'b0, 1'b0, rcwc_pkg::MODE_FR, 16'd1536, 16'd512, 8'd6}},
		// new ack leaves fast recovery: cwnd deflates to ssthresh, no AIMD step
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd2, 1'b1, 1'b1,
			'{8'd0, 1'b1, 1'b0, rcwc_pkg::MODE_AIMD, 16'd512, 16'd512, 8'd2}},
		// timeout halves into ssthresh and restarts slow start
		'{rcwc_pkg::FUNC_TIMEOUT, 4'd15, 8'h5A, 1'b1, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd256, 8'd1}},
		'{rcwc_pkg::FUNC_SEND, 4'd15, 8'd0, 1'b0, 1'b0, '0},
		'{rcwc_pkg::FUNC_SEND, 4'd15, 8'd0, 1'b0, 1'b0, '0},
		// cwnd == ssthresh still grows in slow start
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd3, 1'b1, 1'b0, '0},
		// cwnd > ssthresh: switch to AIMD and take the 1/cwnd step in one event
		'{rcwc_pkg::FUNC_ACK, 4'd15, 8'd4, 1'b1, 1'b0, '0},
		'{rcwc_pkg::FUNC_TIMEOUT, 4'd15, 8'd0, 1'b0, 1'b0, '0},
		'{rcwc_pkg::FUNC_SEND, 4'd0, 8'd0, 1'b1, 1'b1,
			'{8'd1, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd16384, 8'd1}},
		// wrapped distance far past the window
		'{rcwc_pkg::FUNC_ACK, 4'd0, 8'd255, 1'b1, 1'b0, '0},
		'{rcwc_pkg::FUNC_NONE, 4'd5, 8'hAA, 1'b0, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd16384, 8'd1}},
		// timeout on an untouched peer: ssthresh drops below cwnd
		'{rcwc_pkg::FUNC_TIMEOUT, 4'd10, 8'd0, 1'b0, 1'b1,
			'{8'd0, 1'b0, 1'b0, rcwc_pkg::MODE_SS, 16'd256, 16'd128, 8'd1}},
		'{rcwc_pkg::FUNC_SEND, 4'd10, 8'd0, 1'b0, 1'b0, '0},
		'{rcwc_pkg::FUNC_ACK, 4'd10, 8'd1, 1'b1, 1'b0, '0},
		// good ack after duplicates clears the count on peer 0
		'{rcwc_pkg::FUNC_ACK, 4'd0, 8'd1, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rcwc_pkg::LIMIT_W-1:0] cfg_wdata;

	rcwc_req_if req();
	rcwc_rsp_if rsp();

	reno_congestion_window_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor copy of the per-peer tables and the window limit.
	logic [15:0]     cwnd_q  [rcwc_pkg::NUM_PEERS];
	logic [15:0]     ssth_q  [rcwc_pkg::NUM_PEERS];
	rcwc_pkg::mode_t mode_q  [rcwc_pkg::NUM_PEERS];
	logic [7:0]      dups_q  [rcwc_pkg::NUM_PEERS];
	logic [7:0]      acked_q [rcwc_pkg::NUM_PEERS];
	logic [7:0]      sent_q  [rcwc_pkg::NUM_PEERS];
	logic [7:0]      limit_q;

	outcome_t    due_reports [$];   // responses owed by the core, oldest first
	int unsigned issued;            // requests accepted so far
	int unsigned checked;           // responses compared so far
	int unsigned faults;
	int unsigned cycles;
	bit          calm;              // phase without any idling on either side

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Saturating Q8.8 sum.
	function automatic logic [15:0] q_add(input logic [15:0] a, input logic [16:0] b);
		logic [17:0] s;
		s = {2'b00, a} + {1'b0, b};
		return (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
	endfunction

	// Applies one event to the predictor tables and returns the response.
	function automatic outcome_t reno_update(input rcwc_pkg::func_t f,
		input logic [3:0] p, input logic [7:0] s, input logic c);
		outcome_t   r;
		logic [7:0] span;
		logic [7:0] ahead;
		logic [15:0] half;
		r = '0;
		case (f)
		rcwc_pkg::FUNC_ACK: begin
			span  = sent_q[p] - acked_q[p];
			ahead = s - acked_q[p];
			if (c && ahead != 8'd0 && ahead <= span) begin
				r.ack_new = 1'b1;
				dups_q[p] = 8'd0;
				if (mode_q[p] == rcwc_pkg::MODE_SS) begin
					if (cwnd_q[p] <= ssth_q[p])
						cwnd_q[p] = q_add(cwnd_q[p], {1'b0, ONE_Q});
					else
						mode_q[p] = rcwc_pkg::MODE_AIMD;
				end
				if (mode_q[p] == rcwc_pkg::MODE_FR) begin
					cwnd_q[p] = ssth_q[p];
					mode_q[p] = rcwc_pkg::MODE_AIMD;
				end
				// congestion avoidance: + 1/cwnd, truncated
				if (mode_q[p] == rcwc_pkg::MODE_AIMD && cwnd_q[p] > ssth_q[p]
					&& cwnd_q[p] != 16'd0)
					cwnd_q[p] = q_add(cwnd_q[p], 17'(32'h10000 / {16'd0, cwnd_q[p]}));
				acked_q[p] = s;
			end else begin
				if (dups_q[p] != 8'hFF)
					dups_q[p] = dups_q[p] + 8'd1;
				if (mode_q[p] == rcwc_pkg::MODE_FR)
					cwnd_q[p] = q_add(cwnd_q[p], {1'b0, ONE_Q});
				if (dups_q[p] == 8'(rcwc_pkg::DUP_THRESHOLD)) begin
					half       = cwnd_q[p] >> 1;
					ssth_q[p]  = (half < TWO_Q) ? TWO_Q : half;
					cwnd_q[p]  = q_add(ssth_q[p], 17'(rcwc_pkg::DUP_THRESHOLD * 256));
					mode_q[p]  = rcwc_pkg::MODE_FR;
					r.fast_rtx = 1'b1;
				end
			end
		end
		rcwc_pkg::FUNC_TIMEOUT: begin
			ssth_q[p] = cwnd_q[p] >> 1;
			cwnd_q[p] = ONE_Q;
			mode_q[p] = rcwc_pkg::MODE_SS;
		end
		rcwc_pkg::FUNC_SEND: begin
			sent_q[p] = sent_q[p] + 8'd1;
			r.seq     = sent_q[p];
		end
		default: ;
		endcase
		r.mode = mode_q[p];
		r.cwnd = cwnd_q[p];
		r.ssth = ssth_q[p];
		r.eff  = (cwnd_q[p][15:8] < limit_q) ? cwnd_q[p][15:8] : limit_q;
		return r;
	endfunction

	task automatic flag(input string msg);
		faults++;
		if (faults <= 10)
			$display("mismatch, response %0d: %s", checked, msg);
	endtask

	// Present one request after a random gap and hold it until taken; the
	// expected response is queued at the accepting edge.
	task automatic issue(input rcwc_pkg::func_t f, input logic [3:0] p,
		input logic [7:0] s, input logic c, input logic typed = 1'b0,
		input outcome_t want = '0);
		int unsigned gap;
		outcome_t    predicted;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid   <= 1'b1;
		req.func    <= f;
		req.peer    <= p;
		req.ack_seq <= s;
		req.crc_ok  <= c;
		do @(posedge clk); while (req.ready !== 1'b1);
		predicted = reno_update(f, p, s, c);
		due_reports.push_back(typed ? want : predicted);
		issued++;
	endtask

	// Quiesce: drop valid, let every owed response land, then cover the
	// longest request latency before touching the register.
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_limit(input logic [7:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		limit_q = v;
	endtask

	// Mostly well-formed traffic on a few busy peers, plus noise.
	task automatic random_event();
		logic [3:0]  p;
		logic [7:0]  span;
		int unsigned k;
		p = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
		span = sent_q[p] - acked_q[p];
		k = $urandom_range(0, 99);
		if (k < 30 || (k < 58 && span == 8'd0))
			issue(rcwc_pkg::FUNC_SEND, p, 8'($urandom), 1'($urandom));
		else if (k < 58)
			// in-window ack somewhere in (last acked, last sent]
			issue(rcwc_pkg::FUNC_ACK, p, 8'(acked_q[p] + 8'($urandom_range(1, span))), 1'b1);
		else if (k < 70)
			repeat (rcwc_pkg::DUP_THRESHOLD) issue(rcwc_pkg::FUNC_ACK, p, acked_q[p], 1'b1);
		else if (k < 78)
			issue(rcwc_pkg::FUNC_ACK, p, 8'($urandom), 1'b0);
		else if (k < 88)
			issue(rcwc_pkg::FUNC_ACK, p, 8'($urandom), 1'($urandom));
		else if (k < 96)
			issue(rcwc_pkg::FUNC_TIMEOUT, p, 8'($urandom), 1'($urandom));
		else
			issue(rcwc_pkg::FUNC_NONE, p, 8'($urandom), 1'($urandom));
	endtask

	// One peer driven through sequence wrap, the widest in-window ack, fast
	// retransmit, cwnd saturation with the dup count pinned, then a timeout.
	task automatic long_run(input logic [3:0] p);
		int unsigned n;
		n = $urandom_range(250, 300);
		repeat (n) issue(rcwc_pkg::FUNC_SEND, p, 8'($urandom), 1'($urandom));
		if (sent_q[p] == acked_q[p])
			issue(rcwc_pkg::FUNC_SEND, p, 8'($urandom), 1'($urandom));
		issue(rcwc_pkg::FUNC_ACK, p, sent_q[p], 1'b1);
		repeat (260) issue(rcwc_pkg::FUNC_ACK, p, acked_q[p], 1'b1);
		issue(rcwc_pkg::FUNC_TIMEOUT, p, 8'($urandom), 1'($urandom));
	endtask

	// Response side: random back-pressure.
	initial begin
		int unsigned n;
		rsp.ready = 1'b0;
		forever begin
			n = pick_gap();
			@(negedge clk);
			if (n != 0) begin
				rsp.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// Response checker: every accepted response against the oldest expectation.
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			got.seq      = rsp.seq_assigned;
			got.ack_new  = rsp.ack_new;
			got.fast_rtx = rsp.fast_retransmit;
			got.mode     = rcwc_pkg::mode_t'(rsp.mode_out);
			got.cwnd     = rsp.cwnd_out;
			got.ssth     = rsp.ssthresh_out;
			got.eff      = rsp.eff_window;
			if (due_reports.size() == 0) begin
				flag("response with no request outstanding");
			end else begin
				want = due_reports.pop_front();
				if (got.seq !== want.seq)
					flag($sformatf("seq_assigned expected %0d got %0d", want.seq, got.seq));
				if (got.ack_new !== want.ack_new)
					flag($sformatf("ack_new expected %0b got %0b", want.ack_new, got.ack_new));
				if (got.fast_rtx !== want.fast_rtx)
					flag($sformatf("fast_retransmit expected %0b got %0b",
						want.fast_rtx, got.fast_rtx));
				if (got.mode !== want.mode)
					flag($sformatf("mode_out expected %0d got %0d", want.mode, got.mode));
				if (got.cwnd !== want.cwnd)
					flag($sformatf("cwnd_out expected %h got %h", want.cwnd, got.cwnd));
				if (got.ssth !== want.ssth)
					flag($sformatf("ssthresh_out expected %h got %h", want.ssth, got.ssth));
				if (got.eff !== want.eff)
					flag($sformatf("eff_window expected %0d got %0d", want.eff, got.eff));
			end
			checked++;
		end
	end

	// Main sequence: reset, directed table, then randomized phases, each at
	// its own window limit.
	initial begin
		int unsigned target;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		req.valid   = 1'b0;
		req.func    = rcwc_pkg::FUNC_NONE;
		req.peer    = '0;
		req.ack_seq = '0;
		req.crc_ok  = 1'b0;
		calm        = 1'b0;
		limit_q     = 8'd8;
		for (int i = 0; i < rcwc_pkg::NUM_PEERS; i++) begin
			cwnd_q[i]  = ONE_Q;
			ssth_q[i]  = 16'd16384;
			mode_q[i]  = rcwc_pkg::MODE_SS;
			dups_q[i]  = 8'd0;
			acked_q[i] = 8'd0;
			sent_q[i]  = 8'd0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_SCRIPT; i++)
			issue(SCRIPT[i].func, SCRIPT[i].peer, SCRIPT[i].ack_seq, SCRIPT[i].crc_ok,
				SCRIPT[i].typed, SCRIPT[i].want);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			calm = (ph == 3);
			case (ph)
			0: set_limit(8'd255);   // lets a saturated cwnd show up in eff_window
			1: set_limit(8'd1);
			3: set_limit(8'd128);
			default: set_limit(8'($urandom_range(2, 254)));
			endcase
			if (ph == 0)
				long_run(4'($urandom_range(4, 15)));
			target = issued + PHASE_REQS;
			while (issued < target)
				random_event();
			drain();
		end

		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
src/rcwc_pkg.sv
src/rcwc_if.sv
src/rcwc_ram.sv
src/rcwc_div.sv
src/reno_congestion_window_controller_core.sv
verif/reno_congestion_window_controller_core_test.sv
